// File: hdl/ibblur_pkg.sv
`default_nettype none

package ibblur_pkg;

    localparam int SAMPLE_W           = 8;
    localparam int AVG_W              = 8;
    localparam int ROW_PIXELS_W       = 11;
    localparam int ROW_PIXELS_RST     = 1024;
    localparam int MAX_ROW_PIXELS_DEF = 1024;

    localparam int TAPS      = 5;
    localparam int TAP_COUNT = TAPS * TAPS;
    localparam int LANES     = 4;
    localparam int LINE_LEN  = LANES * (TAPS - 1);

    localparam int COL_SUM_W = SAMPLE_W + 3;
    localparam int BOX_SUM_W = SAMPLE_W + 5;

    // floor(x / 25) == (x * 5243) >> 17 for every x up to 25 * 255
    localparam int DIV_MUL   = 5243;
    localparam int DIV_MUL_W = 13;
    localparam int DIV_SHIFT = 17;
    localparam int PROD_W    = BOX_SUM_W + DIV_MUL_W;

    localparam int FIFO_DEPTH = 8;

    function automatic int row_clamp(input int value, input int max_row);
        int r;
        r = value;
        if (r < 1) begin
            r = 1;
        end
        if (r > max_row) begin
            r = max_row;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hdl/interleaved_box_blur_5x5_core.sv
`default_nettype none
// channel   direction  handshake               payload
// input     in         i_valid / o_stall       i_sample, i_is_filler, i_frame_start
// output    out        o_valid / i_stall       o_average
// config    in         i_cfg_we                i_cfg_data (row_pixels)
//
// One byte per cycle unless stalled; a word passes stage 1, stage 2 and the queue.
// Four history reads per cycle, split over two copies of the sample memory
// with two read ports each; the newest row comes straight from the input.
// A config write starts a column refill (input stalled) that rebuilds
// the column sums for the new row length from the stored samples.
// Synchronous active-low reset clears control state; the history is not cleared.
// Output stall backs up into an 8-word queue; input stalls when it is committed.

module interleaved_box_blur_5x5_core #(
    parameter int MAX_ROW_PIXELS = ibblur_pkg::MAX_ROW_PIXELS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic [ibblur_pkg::SAMPLE_W-1:0]     i_sample,
    input  wire logic                                i_is_filler,
    input  wire logic                                i_frame_start,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic      [ibblur_pkg::AVG_W-1:0]        o_average,
    input  wire logic                                i_cfg_we,
    input  wire logic [ibblur_pkg::ROW_PIXELS_W-1:0] i_cfg_data
);

    localparam int DEPTH = 16 * MAX_ROW_PIXELS + 17;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = ibblur_pkg::ROW_PIXELS_W;
    localparam int XW    = (AW > CW) ? AW : CW;
    localparam int SW    = ibblur_pkg::SAMPLE_W;
    localparam int VW    = ibblur_pkg::COL_SUM_W;
    localparam int HW    = ibblur_pkg::BOX_SUM_W;
    localparam int LINE  = ibblur_pkg::LINE_LEN;
    localparam int LW    = $clog2(LINE);
    localparam int LN    = ibblur_pkg::LANES;
    localparam int FD    = ibblur_pkg::FIFO_DEPTH;
    localparam int FW    = $clog2(FD);
    localparam int PW    = $clog2(FD + 1);

    localparam int ROW_RST = ibblur_pkg::row_clamp(ibblur_pkg::ROW_PIXELS_RST, MAX_ROW_PIXELS);
    localparam logic [AW-1:0] OFF1_RST = AW'(4 * ROW_RST);
    localparam logic [AW-1:0] OFF2_RST = AW'(8 * ROW_RST);
    localparam logic [AW-1:0] OFF3_RST = AW'(12 * ROW_RST);
    localparam logic [AW-1:0] OFF4_RST = AW'(16 * ROW_RST);
    localparam logic [AW-1:0] LAG_RST  = AW'(16 * ROW_RST + 16);

    typedef enum logic {ST_RUN, ST_FILL} t_state;

    function automatic logic [AW-1:0] sub_mod(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] d;
        d = {1'b0, a} - {1'b0, b};
        if (d[AW]) begin
            d = d + (AW+1)'(DEPTH);
        end
        return d[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] inc_mod(input logic [AW-1:0] a);
        return (a == AW'(DEPTH - 1)) ? '0 : a + AW'(1);
    endfunction

    t_state          r_state;
    logic [LW-1:0]   r_fill_idx;
    logic [AW-1:0]   r_rslot;
    logic [AW-1:0]   r_slot;
    logic [AW-1:0]   r_count;
    logic [AW-1:0]   r_off1, r_off2, r_off3, r_off4, r_lag;
    logic [SW-1:0]   r_sline [LINE];
    logic [VW-1:0]   r_vline [LINE];
    logic            r_s1_v, r_s1_emit;
    logic [SW-1:0]   r_s1_row0;
    logic            r_s2_v;
    logic [HW-1:0]   r_s2_sum;
    logic [ibblur_pkg::AVG_W-1:0] r_fifo [FD];
    logic [FW-1:0]   r_wptr, r_rptr;
    logic [PW-1:0]   r_fcnt, r_pend;

    logic [XW-1:0]   cfg_ext, eff;
    logic            accept, fill_step, issue, emit, push, pop;
    logic [AW-1:0]   have, base, raddr1, raddr2, raddr3, raddr4;
    logic [SW-1:0]   row0, rd1, rd2, rd3, rd4;
    logic [VW-1:0]   col_sum;
    logic [HW-1:0]   box_sum;
    logic [ibblur_pkg::PROD_W-1:0] prod;

    assign o_stall   = (r_state != ST_RUN) || (r_pend == PW'(FD));
    assign accept    = i_valid && !o_stall;
    assign fill_step = (r_state == ST_FILL);
    assign issue     = accept || fill_step;
    assign have      = i_frame_start ? '0 : r_count;
    assign emit      = (have >= r_lag);
    assign base      = fill_step ? r_rslot : r_slot;
    assign raddr1    = sub_mod(base, r_off1);
    assign raddr2    = sub_mod(base, r_off2);
    assign raddr3    = sub_mod(base, r_off3);
    assign raddr4    = sub_mod(base, r_off4);
    assign row0      = fill_step ? r_sline[~r_fill_idx] : (i_is_filler ? '0 : i_sample);

    always_comb begin
        cfg_ext = XW'(i_cfg_data);
        if (cfg_ext == '0) begin
            eff = XW'(1);
        end else if (cfg_ext > XW'(MAX_ROW_PIXELS)) begin
            eff = XW'(MAX_ROW_PIXELS);
        end else begin
            eff = cfg_ext;
        end
    end

    ibblur_hist_mem #(.DW(SW), .DEPTH(DEPTH), .AW(AW)) u_mem_near (
        .i_clk     (i_clk),
        .i_we      (accept),
        .i_waddr   (r_slot),
        .i_wdata   (row0),
        .i_re      (issue),
        .i_raddr_a (raddr1),
        .i_raddr_b (raddr2),
        .o_rdata_a (rd1),
        .o_rdata_b (rd2)
    );

    ibblur_hist_mem #(.DW(SW), .DEPTH(DEPTH), .AW(AW)) u_mem_far (
        .i_clk     (i_clk),
        .i_we      (accept),
        .i_waddr   (r_slot),
        .i_wdata   (row0),
        .i_re      (issue),
        .i_raddr_a (raddr3),
        .i_raddr_b (raddr4),
        .o_rdata_a (rd3),
        .o_rdata_b (rd4)
    );

    // row length change: replay the last LINE positions to rebuild column sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_RUN;
            r_fill_idx <= '0;
            r_rslot    <= '0;
        end else if (i_cfg_we) begin
            r_state    <= ST_FILL;
            r_fill_idx <= '0;
            r_rslot    <= sub_mod(r_slot, AW'(LINE));
        end else begin
            unique case (r_state)
                ST_RUN: begin
                    r_fill_idx <= '0;
                end
                ST_FILL: begin
                    r_fill_idx <= r_fill_idx + LW'(1);
                    r_rslot    <= inc_mod(r_rslot);
                    if (r_fill_idx == LW'(LINE - 1)) begin
                        r_state <= ST_RUN;
                    end
                end
                default: begin
                    r_state <= ST_RUN;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off1 <= OFF1_RST;
            r_off2 <= OFF2_RST;
            r_off3 <= OFF3_RST;
            r_off4 <= OFF4_RST;
            r_lag  <= LAG_RST;
        end else if (i_cfg_we) begin
            r_off1 <= AW'(eff << 2);
            r_off2 <= AW'(eff << 3);
            r_off3 <= AW'((eff << 3) + (eff << 2));
            r_off4 <= AW'(eff << 4);
            r_lag  <= AW'((eff << 4) + XW'(16));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= '0;
            r_count <= '0;
        end else if (accept) begin
            r_slot  <= inc_mod(r_slot);
            r_count <= (have < AW'(DEPTH - 1)) ? have + AW'(1) : have;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sline[0] <= row0;
            for (int i = 1; i < LINE; i++) begin
                r_sline[i] <= r_sline[i-1];
            end
        end
    end

    // stage 1: column sum, box sum from the column line
    assign col_sum = VW'(r_s1_row0) + VW'(rd1) + VW'(rd2) + VW'(rd3) + VW'(rd4);

    always_comb begin
        box_sum = HW'(col_sum);
        for (int k = 1; k < ibblur_pkg::TAPS; k++) begin
            box_sum = box_sum + HW'(r_vline[k*LN - 1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v    <= 1'b0;
            r_s1_emit <= 1'b0;
            r_s2_v    <= 1'b0;
        end else begin
            r_s1_v    <= issue;
            r_s1_emit <= accept && emit;
            r_s2_v    <= r_s1_v && r_s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_row0 <= row0;
        r_s2_sum  <= box_sum;
        if (r_s1_v) begin
            r_vline[0] <= col_sum;
            for (int i = 1; i < LINE; i++) begin
                r_vline[i] <= r_vline[i-1];
            end
        end
    end

    // stage 2: divide by 25 and queue
    assign prod = ibblur_pkg::PROD_W'(r_s2_sum)
                * ibblur_pkg::PROD_W'(ibblur_pkg::DIV_MUL);
    assign push = r_s2_v;
    assign pop  = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wptr] <= prod[ibblur_pkg::DIV_SHIFT +: ibblur_pkg::AVG_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fcnt <= '0;
            r_pend <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + FW'(1);
            end
            if (pop) begin
                r_rptr <= r_rptr + FW'(1);
            end
            r_fcnt <= r_fcnt + PW'(push) - PW'(pop);
            r_pend <= r_pend + PW'(accept && emit) - PW'(pop);
        end
    end

    assign o_valid   = (r_fcnt != '0);
    assign o_average = r_fifo[r_rptr];

    a_queue_within_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fcnt <= r_pend)
        else $error("queue holds more words than were committed");

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= PW'(FD))
        else $error("committed words exceed queue depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && r_fcnt == PW'(FD)) |-> pop)
        else $error("push into full queue");

    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue |-> (raddr1 < AW'(DEPTH) && raddr4 < AW'(DEPTH) && r_slot < AW'(DEPTH)))
        else $error("history address out of range");

    a_fill_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == ST_FILL) |-> !r_s1_emit || $past(accept))
        else $error("emitting word issued during refill");

endmodule

`default_nettype wire

// File: hdl/ibblur_hist_mem.sv
`default_nettype none

module ibblur_hist_mem #(
    parameter int DW    = ibblur_pkg::SAMPLE_W,
    parameter int DEPTH = 16 * ibblur_pkg::MAX_ROW_PIXELS_DEF + 17,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr_a,
    input  wire logic [AW-1:0] i_raddr_b,
    output logic      [DW-1:0] o_rdata_a,
    output logic      [DW-1:0] o_rdata_b
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

`default_nettype wire
